/* rtl/assert_macros.svh */
// assertion helpers shared by the scheduler rtl
// depends on nothing; each macro takes a label, a clock, an active-low reset and the checked terms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

/* rtl/cts_pkg.sv */
// types, codes and constants of the cooperative task scheduler
// used by the channel interfaces, the slot table and the top level
`default_nettype none

package cts_pkg;

  localparam int unsigned TaskSlots = 16;
  localparam int unsigned MaxOut    = 16;
  localparam int unsigned HandleW   = 16;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ActW      = 2;
  localparam int unsigned ErrW      = 2;
  localparam int unsigned DcntW     = $clog2(MaxOut + 1);
  localparam logic [DcntW-1:0] DcntMax = DcntW'(MaxOut);

  typedef enum logic [ActW-1:0] {
    ACT_ADD      = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_e;

  typedef enum logic [KindW-1:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_DELETED   = 3'd2,
    KIND_DEL_EMPTY = 3'd3,
    KIND_RUN       = 3'd4,
    KIND_NONE_DUE  = 3'd5
  } kind_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_MANY  = 2'd1,
    ERR_NO_DELETE = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  // one table entry
  typedef struct packed {
    logic               due;
    logic [HandleW-1:0] period;
    logic [HandleW-1:0] countdown;
    logic [HandleW-1:0] handle;
  } slot_t;

  // table write command
  typedef struct packed {
    logic wr;
    logic clr;
  } tbl_cmd_t;

endpackage

`default_nettype wire

/* rtl/cts_if.sv */
// valid/ready channel interfaces of the scheduler: request words in, result words out
// depends on cts_pkg for field widths
`default_nettype none

interface cts_in_if;
  logic                        valid;
  logic                        ready;
  logic [cts_pkg::ActW-1:0]    action;
  logic [cts_pkg::HandleW-1:0] task_handle;
  logic [cts_pkg::HandleW-1:0] first_delay;
  logic [cts_pkg::HandleW-1:0] repeat_period;
  logic [cts_pkg::SlotW-1:0]   slot;

  modport source (
    output valid, action, task_handle, first_delay, repeat_period, slot,
    input  ready
  );
  modport sink (
    input  valid, action, task_handle, first_delay, repeat_period, slot,
    output ready
  );
endinterface

interface cts_out_if;
  logic                        valid;
  logic                        ready;
  logic [cts_pkg::KindW-1:0]   kind;
  logic [cts_pkg::SlotW-1:0]   slot_index;
  logic [cts_pkg::HandleW-1:0] run_handle;
  logic                        last;
  logic [cts_pkg::ErrW-1:0]    sticky_error;

  modport source (
    output valid, kind, slot_index, run_handle, last, sticky_error,
    input  ready
  );
  modport sink (
    input  valid, kind, slot_index, run_handle, last, sticky_error,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/cooperative_task_scheduler.sv */
// add walks from slot 0 to a free slot or the last one; delete checks only its selected slot;
// tick walks all TASK_SLOTS slots, dispatch walks them and then sends the final word from ST_FIN.
// one slot per cycle unless a result word waits; the slot table has one read port, read data registered.
// a waiting result word stalls every action but tick; one request is in work at a time.
// reset (async, active low) clears the control state, the sticky error and the table valid
// bits, so every slot reads as free right after reset with no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module cooperative_task_scheduler #(
  parameter int unsigned TASK_SLOTS = cts_pkg::TaskSlots
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cts_in_if.sink     in_i,
  cts_out_if.source  out_o
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] LastSlot = CW'(TASK_SLOTS - 1);

  cts_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    cur_q, cur_d;
  logic [cts_pkg::DcntW-1:0] dcnt_q, dcnt_d;
  cts_pkg::err_e    err_q, err_d;

  // request being worked on
  cts_pkg::action_e            act_q;
  logic [cts_pkg::HandleW-1:0] hdl_q, dly_q, per_q;
  logic [cts_pkg::SlotW-1:0]   sel_q;
  logic                        sel_ok_q;

  // dispatched word held back until we know whether it is the last one
  logic                        held_vld_q, held_vld_d;
  logic [cts_pkg::SlotW-1:0]   held_idx_q, held_idx_d;
  logic [cts_pkg::HandleW-1:0] held_hdl_q, held_hdl_d;

  // output register
  logic                        out_vld_q;
  cts_pkg::kind_e              out_kind_q, push_kind;
  logic [cts_pkg::SlotW-1:0]   out_idx_q, push_idx;
  logic [cts_pkg::HandleW-1:0] out_hdl_q, push_hdl;
  logic                        out_last_q, push_last;
  cts_pkg::err_e               out_err_q;
  logic                        push;

  logic [IW-1:0]      rd_addr, cur_idx, nxt_idx;
  cts_pkg::slot_t     ent, wr_data;
  cts_pkg::tbl_cmd_t  cmd;
  logic               out_free, last_slot, occupied, accept, in_sel_ok;

  cts_table #(
    .TASK_SLOTS (TASK_SLOTS),
    .IW         (IW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (ent),
    .cmd_i     (cmd),
    .wr_addr_i (cur_idx),
    .wr_data_i (wr_data)
  );

  assign out_free  = !out_vld_q || out_o.ready;
  assign cur_idx   = cur_q[IW-1:0];
  assign last_slot = (cur_q == LastSlot);
  assign nxt_idx   = last_slot ? '0 : IW'(cur_q + 1'b1);
  assign occupied  = (ent.handle != '0);
  assign in_i.ready = (state_q == cts_pkg::ST_IDLE);
  assign accept    = in_i.valid && in_i.ready;
  assign in_sel_ok = (32'(in_i.slot) < TASK_SLOTS);

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    dcnt_d     = dcnt_q;
    err_d      = err_q;
    held_vld_d = held_vld_q;
    held_idx_d = held_idx_q;
    held_hdl_d = held_hdl_q;
    push       = 1'b0;
    push_kind  = cts_pkg::KIND_ADDED;
    push_idx   = '0;
    push_hdl   = '0;
    push_last  = 1'b1;
    cmd        = '0;
    wr_data    = ent;
    rd_addr    = '0;

    case (state_q)
      cts_pkg::ST_IDLE: begin
        if ((cts_pkg::action_e'(in_i.action) == cts_pkg::ACT_DELETE) && in_sel_ok) begin
          rd_addr = IW'(in_i.slot);
        end
        if (accept) begin
          state_d    = cts_pkg::ST_RUN;
          dcnt_d     = '0;
          held_vld_d = 1'b0;
          cur_d      = '0;
          if ((cts_pkg::action_e'(in_i.action) == cts_pkg::ACT_DELETE) && in_sel_ok) begin
            cur_d = CW'(in_i.slot);
          end
        end
      end

      cts_pkg::ST_RUN: begin
        case (act_q)
          cts_pkg::ACT_ADD: begin
            rd_addr = out_free ? nxt_idx : cur_idx;
            if (out_free) begin
              if (!occupied) begin
                cmd.wr            = 1'b1;
                wr_data.due       = 1'b0;
                wr_data.period    = per_q;
                wr_data.countdown = dly_q;
                wr_data.handle    = hdl_q;
                push      = 1'b1;
                push_kind = cts_pkg::KIND_ADDED;
                push_idx  = cts_pkg::SlotW'(cur_q);
                state_d   = cts_pkg::ST_IDLE;
              end else if (last_slot) begin
                err_d     = cts_pkg::ERR_TOO_MANY;
                push      = 1'b1;
                push_kind = cts_pkg::KIND_FULL;
                state_d   = cts_pkg::ST_IDLE;
              end else begin
                cur_d = cur_q + 1'b1;
              end
            end
          end

          cts_pkg::ACT_DELETE: begin
            rd_addr = cur_idx;
            if (out_free) begin
              cmd.clr   = sel_ok_q;
              push      = 1'b1;
              push_idx  = sel_q;
              push_kind = cts_pkg::KIND_DELETED;
              if (!sel_ok_q || !occupied) begin
                push_kind = cts_pkg::KIND_DEL_EMPTY;
                err_d     = cts_pkg::ERR_NO_DELETE;
              end
              state_d = cts_pkg::ST_IDLE;
            end
          end

          cts_pkg::ACT_TICK: begin
            rd_addr = nxt_idx;
            if (occupied) begin
              cmd.wr = 1'b1;
              if (ent.countdown == '0) begin
                wr_data.due = 1'b1;
                if (ent.period != '0) begin
                  wr_data.countdown = ent.period;
                end
              end else begin
                wr_data.countdown = ent.countdown - 1'b1;
              end
            end
            if (last_slot) begin
              state_d = cts_pkg::ST_IDLE;
            end else begin
              cur_d = cur_q + 1'b1;
            end
          end

          cts_pkg::ACT_DISPATCH: begin
            rd_addr = out_free ? nxt_idx : cur_idx;
            if (out_free) begin
              if (ent.due && (dcnt_q < cts_pkg::DcntMax)) begin
                dcnt_d = dcnt_q + 1'b1;
                // one-shot tasks leave the table once run
                if (ent.period == '0) begin
                  cmd.clr = 1'b1;
                end else begin
                  cmd.wr      = 1'b1;
                  wr_data.due = 1'b0;
                end
                if (held_vld_q) begin
                  push      = 1'b1;
                  push_kind = cts_pkg::KIND_RUN;
                  push_idx  = held_idx_q;
                  push_hdl  = held_hdl_q;
                  push_last = 1'b0;
                end
                held_vld_d = 1'b1;
                held_idx_d = cts_pkg::SlotW'(cur_q);
                held_hdl_d = ent.handle;
              end
              if (last_slot) begin
                state_d = cts_pkg::ST_FIN;
              end else begin
                cur_d = cur_q + 1'b1;
              end
            end
          end

          default: begin
            state_d = cts_pkg::ST_IDLE;
          end
        endcase
      end

      cts_pkg::ST_FIN: begin
        if (out_free) begin
          push = 1'b1;
          if (held_vld_q) begin
            push_kind = cts_pkg::KIND_RUN;
            push_idx  = held_idx_q;
            push_hdl  = held_hdl_q;
          end else begin
            push_kind = cts_pkg::KIND_NONE_DUE;
          end
          held_vld_d = 1'b0;
          state_d    = cts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cts_pkg::ST_IDLE;
      cur_q      <= '0;
      dcnt_q     <= '0;
      err_q      <= cts_pkg::ERR_NONE;
      held_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      dcnt_q     <= dcnt_d;
      err_q      <= err_d;
      held_vld_q <= held_vld_d;
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_idx_q <= held_idx_d;
    held_hdl_q <= held_hdl_d;
    if (accept) begin
      act_q    <= cts_pkg::action_e'(in_i.action);
      hdl_q    <= in_i.task_handle;
      dly_q    <= in_i.first_delay;
      per_q    <= in_i.repeat_period;
      sel_q    <= in_i.slot;
      sel_ok_q <= in_sel_ok;
    end
    if (push) begin
      out_kind_q <= push_kind;
      out_idx_q  <= push_idx;
      out_hdl_q  <= push_hdl;
      out_last_q <= push_last;
      out_err_q  <= err_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.slot_index   = out_idx_q;
  assign out_o.run_handle   = out_hdl_q;
  assign out_o.last         = out_last_q;
  assign out_o.sticky_error = out_err_q;

  `ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, accept, state_q != cts_pkg::ST_IDLE)
  `ASSERT_IMPL(a_held_only_dispatch, clk_i, rst_ni, held_vld_q, act_q == cts_pkg::ACT_DISPATCH)
  `ASSERT_ALWAYS(a_dcnt_bound, clk_i, rst_ni, dcnt_q <= cts_pkg::DcntMax)
  `ASSERT_IMPL(a_cur_in_table, clk_i, rst_ni, state_q == cts_pkg::ST_RUN, cur_q <= LastSlot)
  `ASSERT_IMPL(a_push_needs_room, clk_i, rst_ni, push, out_free)

endmodule

`default_nettype wire

/* rtl/cts_table.sv */
// slot table: one synchronous memory, one read and one write port, read data registered
// per-entry valid flops make unwritten or cleared entries read as zero; depends on cts_pkg
`default_nettype none

module cts_table #(
  parameter int unsigned TASK_SLOTS = cts_pkg::TaskSlots,
  parameter int unsigned IW         = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [IW-1:0]     rd_addr_i,
  output cts_pkg::slot_t         rd_data_o,
  input  wire cts_pkg::tbl_cmd_t cmd_i,
  input  wire logic [IW-1:0]     wr_addr_i,
  input  wire cts_pkg::slot_t    wr_data_i
);

  cts_pkg::slot_t        mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] vld_q;
  cts_pkg::slot_t        rd_data_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        vld_q[wr_addr_i] <= 1'b1;
      end else if (cmd_i.clr) begin
        vld_q[wr_addr_i] <= 1'b0;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* sim/tb_cooperative_task_scheduler.sv */
// self-checking bench of the cooperative task scheduler: request words in, result words out
// depends on cts_pkg and the cts_in_if / cts_out_if channel interfaces of the rtl
`timescale 1ns / 100ps

module tb_cooperative_task_scheduler;
  import cts_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandomReqs  = 304;

  typedef struct packed {
    action_e            act;
    logic [HandleW-1:0] handle;
    logic [HandleW-1:0] delay;
    logic [HandleW-1:0] period;
    logic [SlotW-1:0]   slot;
  } sched_req_t;

  typedef struct packed {
    kind_e              kind;
    logic [SlotW-1:0]   slot_index;
    logic [HandleW-1:0] run_handle;
    logic               last;
    logic [ErrW-1:0]    sticky_error;
  } sched_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  cts_in_if  req_if ();
  cts_out_if rsp_if ();

  cooperative_task_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // shadow copy of the task table
  logic [HandleW-1:0] tbl_handle [TaskSlots];
  logic [HandleW-1:0] tbl_count  [TaskSlots];
  logic [HandleW-1:0] tbl_period [TaskSlots];
  logic               tbl_due    [TaskSlots];
  logic [ErrW-1:0]    err_reg;

  sched_req_t  request_q [$];
  sched_word_t pending_words [$];

  int unsigned n_fail;
  int unsigned n_words;
  int unsigned act_count [4];
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned recv_gap;
  bit          calm;

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void free_slot(int unsigned i);
    tbl_handle[i] = '0;
    tbl_count[i]  = '0;
    tbl_period[i] = '0;
    tbl_due[i]    = 1'b0;
  endfunction

  function automatic void push_word(kind_e k, int unsigned idx, logic [HandleW-1:0] h,
                                    logic l);
    sched_word_t w;
    w.kind         = k;
    w.slot_index   = idx[SlotW-1:0];
    w.run_handle   = h;
    w.last         = l;
    w.sticky_error = err_reg;
    pending_words.push_back(w);
  endfunction

  // updates the shadow table for one request and queues the words it must produce
  function automatic void advance_task_table(sched_req_t r);
    int          free_idx;
    int unsigned n;
    kind_e       k;
    sched_word_t w;
    case (r.act)
      ACT_ADD: begin
        free_idx = -1;
        for (int i = 0; i < TaskSlots; i++)
          if (free_idx < 0 && tbl_handle[i] == '0) free_idx = i;
        if (free_idx < 0) begin
          err_reg = ERR_TOO_MANY;
          push_word(KIND_FULL, 0, '0, 1'b1);
        end else begin
          tbl_handle[free_idx] = r.handle;
          tbl_count[free_idx]  = r.delay;
          tbl_period[free_idx] = r.period;
          tbl_due[free_idx]    = 1'b0;
          push_word(KIND_ADDED, free_idx, '0, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (tbl_handle[r.slot] == '0) begin
          err_reg = ERR_NO_DELETE;
          k = KIND_DEL_EMPTY;
        end else begin
          k = KIND_DELETED;
        end
        free_slot(r.slot);
        push_word(k, r.slot, '0, 1'b1);
      end
      ACT_TICK: begin
        for (int i = 0; i < TaskSlots; i++) begin
          if (tbl_handle[i] != '0) begin
            if (tbl_count[i] == '0) begin
              tbl_due[i] = 1'b1;
              if (tbl_period[i] != '0) tbl_count[i] = tbl_period[i];
            end else begin
              tbl_count[i] = tbl_count[i] - 1'b1;
            end
          end
        end
      end
      default: begin
        n = 0;
        for (int i = 0; i < TaskSlots; i++) begin
          if (n < MaxOut && tbl_due[i]) begin
            push_word(KIND_RUN, i, tbl_handle[i], 1'b0);
            n++;
            tbl_due[i] = 1'b0;
            // one-shot tasks leave the table once run
            if (tbl_period[i] == '0) free_slot(i);
          end
        end
        if (n == 0) begin
          push_word(KIND_NONE_DUE, 0, '0, 1'b1);
        end else begin
          w = pending_words.pop_back();
          w.last = 1'b1;
          pending_words.push_back(w);
        end
      end
    endcase
  endfunction

  function automatic sched_req_t mk_req(action_e a, logic [HandleW-1:0] h,
                                        logic [HandleW-1:0] d, logic [HandleW-1:0] p,
                                        logic [SlotW-1:0] s);
    sched_req_t r;
    r.act    = a;
    r.handle = h;
    r.delay  = d;
    r.period = p;
    r.slot   = s;
    return r;
  endfunction

  function automatic sched_req_t random_request();
    sched_req_t  r;
    int unsigned p;
    r.slot = SlotW'($urandom_range(0, TaskSlots - 1));
    p = $urandom_range(0, 99);
    // mostly plausible task traffic, a tenth raw noise
    if (p < 10) begin
      r.act    = action_e'($urandom_range(0, 3));
      r.handle = HandleW'($urandom_range(0, 65535));
      r.delay  = HandleW'($urandom_range(0, 65535));
      r.period = HandleW'($urandom_range(0, 65535));
      return r;
    end
    p = $urandom_range(0, 99);
    if (p < 36)      r.act = ACT_ADD;
    else if (p < 54) r.act = ACT_DELETE;
    else if (p < 78) r.act = ACT_TICK;
    else             r.act = ACT_DISPATCH;
    p = $urandom_range(0, 99);
    if (p < 4)      r.handle = '0;
    else if (p < 8) r.handle = '1;
    else            r.handle = HandleW'($urandom_range(1, 65535));
    p = $urandom_range(0, 99);
    if (p < 75)      r.delay = HandleW'($urandom_range(0, 3));
    else if (p < 90) r.delay = HandleW'($urandom_range(4, 20));
    else             r.delay = HandleW'($urandom_range(0, 65535));
    p = $urandom_range(0, 99);
    if (p < 30)      r.period = '0;
    else if (p < 75) r.period = HandleW'($urandom_range(1, 4));
    else if (p < 90) r.period = HandleW'($urandom_range(5, 20));
    else             r.period = HandleW'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic void report_mismatch(string field, logic [HandleW-1:0] exp_v,
                                          logic [HandleW-1:0] got_v);
    $display("%0t: %s mismatch, expected %h got %h", $time, field, exp_v, got_v);
    n_fail++;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 128 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : driver
    sched_req_t r;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_gap = 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (send_gap != 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        r = request_q.pop_front();
        req_if.valid         <= 1'b1;
        req_if.action        <= r.act;
        req_if.task_handle   <= r.handle;
        req_if.first_delay   <= r.delay;
        req_if.repeat_period <= r.period;
        req_if.slot          <= r.slot;
        send_gap = idle_len();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sched_req_t  r;
    sched_word_t exp_w;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        r.act    = action_e'(req_if.action);
        r.handle = req_if.task_handle;
        r.delay  = req_if.first_delay;
        r.period = req_if.repeat_period;
        r.slot   = req_if.slot;
        act_count[req_if.action]++;
        advance_task_table(r);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        n_words++;
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word, expected none got kind %0d slot %0d handle %h",
                   $time, rsp_if.kind, rsp_if.slot_index, rsp_if.run_handle);
          n_fail++;
        end else begin
          exp_w = pending_words.pop_front();
          if (rsp_if.kind !== exp_w.kind)
            report_mismatch("kind", exp_w.kind, rsp_if.kind);
          if (rsp_if.slot_index !== exp_w.slot_index)
            report_mismatch("slot_index", exp_w.slot_index, rsp_if.slot_index);
          if (rsp_if.run_handle !== exp_w.run_handle)
            report_mismatch("run_handle", exp_w.run_handle, rsp_if.run_handle);
          if (rsp_if.last !== exp_w.last)
            report_mismatch("last", exp_w.last, rsp_if.last);
          if (rsp_if.sticky_error !== exp_w.sticky_error)
            report_mismatch("sticky_error", exp_w.sticky_error, rsp_if.sticky_error);
        end
        recv_gap = idle_len();
      end
      if (recv_gap != 0) begin
        recv_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    req_if.valid         = 1'b0;
    req_if.action        = ACT_ADD;
    req_if.task_handle   = '0;
    req_if.first_delay   = '0;
    req_if.repeat_period = '0;
    req_if.slot          = '0;
    rsp_if.ready         = 1'b0;
    n_fail      = 0;
    n_words     = 0;
    cycle_count = 0;
    calm        = 1'b0;
    for (int i = 0; i < 4; i++) act_count[i] = 0;
    for (int i = 0; i < TaskSlots; i++) free_slot(i);
    err_reg = ERR_NONE;

    // empty table: nothing due, delete of an empty slot
    request_q.push_back(mk_req(ACT_DISPATCH, '0, '0, '0, '0));
    request_q.push_back(mk_req(ACT_DELETE, '0, '0, '0, 4'hF));
    // zero handle takes slot 0 but leaves it free
    request_q.push_back(mk_req(ACT_ADD, '0, '1, '1, '0));
    request_q.push_back(mk_req(ACT_ADD, '1, '0, '0, '0));
    request_q.push_back(mk_req(ACT_ADD, 16'h0001, '0, 16'h0001, '0));
    request_q.push_back(mk_req(ACT_ADD, 16'h8000, 16'h0001, '1, '0));
    request_q.push_back(mk_req(ACT_TICK, '0, '0, '0, '0));
    // one-shot in slot 0 runs and leaves
    request_q.push_back(mk_req(ACT_DISPATCH, '0, '0, '0, '0));
    for (int k = 0; k < 14; k++)
      request_q.push_back(mk_req(ACT_ADD, HandleW'(16'h0101 * (k + 1)), '0,
                                 (k == 13) ? 16'hFFFF : HandleW'(k + 1), '0));
    request_q.push_back(mk_req(ACT_ADD, 16'h5A5A, '0, '0, '0));
    request_q.push_back(mk_req(ACT_TICK, '0, '0, '0, '0));
    request_q.push_back(mk_req(ACT_TICK, '0, '0, '0, '0));
    // every slot due: a full burst of run words
    request_q.push_back(mk_req(ACT_DISPATCH, '0, '0, '0, '0));

    for (int k = 0; k < RandomReqs; k++) request_q.push_back(random_request());

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || req_if.valid || pending_words.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("requests: %0d adds, %0d deletes, %0d ticks, %0d dispatches",
             act_count[ACT_ADD], act_count[ACT_DELETE], act_count[ACT_TICK],
             act_count[ACT_DISPATCH]);
    $display("result words compared: %0d, mismatches: %0d", n_words, n_fail);
    if (n_fail == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
